/* design/qalu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion ALU package
// Operation codes, field widths and the register reset value shared by the
// quaternion ALU and its port checker.
// ----------------------------------------------------------------------------
package qalu_pkg;

    localparam int COMP_W  = 32;
    localparam int OP_W    = 4;
    localparam int TOL_W   = 31;
    localparam int IN_W    = 264;
    localparam int OUT_W   = 136;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd655;

    typedef enum logic [OP_W-1:0] {
        OP_MUL    = 4'd0,
        OP_ADD    = 4'd1,
        OP_SUB    = 4'd2,
        OP_NEG    = 4'd3,
        OP_SCALE  = 4'd4,
        OP_DOT    = 4'd5,
        OP_NORMSQ = 4'd6,
        OP_ROTATE = 4'd7,
        OP_CMP    = 4'd8
    } op_t;

    // Bit positions of the status flags in the result data.
    localparam int OVF_BIT = 128;
    localparam int EQ_BIT  = 129;

endpackage

/* design/quaternion_alu_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion ALU
// A request passes through the six-stage multiplier pipeline to result valid;
// throughput is one request per cycle while m_tready does not stall the output.
// Each stage stalls only when it is full and the stage after it cannot take.
// rst_n is asynchronous active low: it empties the pipeline and loads the
// equality tolerance with its default of 655 (about 0.01 in Q16.16).
// ----------------------------------------------------------------------------
module quaternion_alu_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // Equality tolerance write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [30:0]  cfg_data,
    // Request: operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z (4 + 8 x 32, zero pad)
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [263:0] s_tdata,
    // Result: r_w, r_x, r_y, r_z (4 x 32), overflow, equal (zero pad)
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata
);

    localparam int CW     = qalu_pkg::COMP_W;
    localparam int PROD_W = 2 * CW - FRAC_BITS;
    localparam int ACC_W  = PROD_W + 3;

    typedef logic signed [CW-1:0]     comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    function automatic acc_t ext_c(input comp_t v);
        return {{(ACC_W-CW){v[CW-1]}}, v};
    endfunction

    function automatic acc_t ext_p(input prod_t v);
        return {{(ACC_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    // Clamp to 32 bits; the top bit of the result is the overflow mark.
    function automatic logic [CW:0] sat(input acc_t v);
        logic hi_ok;
        hi_ok = (&v[ACC_W-1:CW-1]) | ~(|v[ACC_W-1:CW-1]);
        if (hi_ok)
            return {1'b0, v[CW-1:0]};
        else if (v[ACC_W-1])
            return {1'b1, 1'b1, {(CW-1){1'b0}}};
        else
            return {1'b1, 1'b0, {(CW-1){1'b1}}};
    endfunction

    // Tolerance register
    logic [qalu_pkg::TOL_W-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= qalu_pkg::TOL_RESET;
        else if (cfg_valid)
            tol_reg <= cfg_data;
    end

    // Stage handshake: a stage loads when it is empty or its successor loads.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !v6_reg || m_tready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = v6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // Stage 1: request register
    logic [qalu_pkg::OP_W-1:0] op1_reg;
    comp_t a1_reg [4];
    comp_t b1_reg [4];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg <= s_tdata[3:0];
            for (int i = 0; i < 4; i++)
            begin
                a1_reg[i] <= s_tdata[4 + CW*i +: CW];
                b1_reg[i] <= s_tdata[4 + CW*(i+4) +: CW];
            end
        end
    end

    // Operand selection for the sixteen first-round multipliers.
    // Slots follow the Hamilton product; the rotate cross products use
    // slots 6, 7, 10, 11, 14 and 15.
    comp_t ma [16];
    comp_t mb [16];

    always_comb
    begin
        ma[0]  = a1_reg[0]; mb[0]  = b1_reg[0];
        ma[1]  = a1_reg[1]; mb[1]  = b1_reg[1];
        ma[2]  = a1_reg[2]; mb[2]  = b1_reg[2];
        ma[3]  = a1_reg[3]; mb[3]  = b1_reg[3];
        ma[4]  = a1_reg[0]; mb[4]  = b1_reg[1];
        ma[5]  = a1_reg[1]; mb[5]  = b1_reg[0];
        ma[6]  = a1_reg[2]; mb[6]  = b1_reg[3];
        ma[7]  = a1_reg[3]; mb[7]  = b1_reg[2];
        ma[8]  = a1_reg[0]; mb[8]  = b1_reg[2];
        ma[9]  = a1_reg[2]; mb[9]  = b1_reg[0];
        ma[10] = a1_reg[3]; mb[10] = b1_reg[1];
        ma[11] = a1_reg[1]; mb[11] = b1_reg[3];
        ma[12] = a1_reg[0]; mb[12] = b1_reg[3];
        ma[13] = a1_reg[3]; mb[13] = b1_reg[0];
        ma[14] = a1_reg[1]; mb[14] = b1_reg[2];
        ma[15] = a1_reg[2]; mb[15] = b1_reg[1];
        case (op1_reg)
            qalu_pkg::OP_NORMSQ:
            begin
                mb[1] = a1_reg[1];
                mb[2] = a1_reg[2];
                mb[3] = a1_reg[3];
                mb[0] = a1_reg[0];
            end
            qalu_pkg::OP_SCALE:
            begin
                ma[4] = a1_reg[1]; mb[4] = b1_reg[0];
                ma[8] = a1_reg[2]; mb[8] = b1_reg[0];
                ma[12] = a1_reg[3]; mb[12] = b1_reg[0];
            end
            default:
            begin
            end
        endcase
    end

    // Simple operations and compare, resolved in stage 2.
    acc_t simple [4];
    logic eq_c;

    always_comb
    begin
        logic [CW:0] d;
        logic [CW:0] m;
        eq_c = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            d = {a1_reg[i][CW-1], a1_reg[i]} - {b1_reg[i][CW-1], b1_reg[i]};
            m = d[CW] ? (~d + 1'b1) : d;
            if (!(m < {2'b00, tol_reg}))
                eq_c = 1'b0;
            case (op1_reg)
                qalu_pkg::OP_ADD: simple[i] = ext_c(a1_reg[i]) + ext_c(b1_reg[i]);
                qalu_pkg::OP_SUB: simple[i] = ext_c(a1_reg[i]) - ext_c(b1_reg[i]);
                qalu_pkg::OP_NEG: simple[i] = -ext_c(a1_reg[i]);
                default:          simple[i] = '0;
            endcase
        end
    end

    // Stage 2: first-round products, truncated toward minus infinity.
    prod_t p2_reg [16];
    acc_t  s2_reg [4];
    logic  eq2_reg;
    logic [qalu_pkg::OP_W-1:0] op2_reg;
    comp_t a2_reg [4];
    comp_t b2_reg [4];

    for (genvar g = 0; g < 16; g++)
    begin : g_mul1
        logic signed [2*CW-1:0] prod;
        assign prod = ma[g] * mb[g];
        always_ff @(posedge clk)
        begin
            if (en2)
                p2_reg[g] <= prod[2*CW-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            op2_reg <= op1_reg;
            eq2_reg <= (op1_reg == qalu_pkg::OP_CMP) && eq_c;
            s2_reg  <= simple;
            a2_reg  <= a1_reg;
            b2_reg  <= b1_reg;
        end
    end

    // Stage 3: sums of products, and the saturated rotate vector t.
    acc_t  acc3_next [4];
    comp_t t3_next [3];
    logic  tovf3_next;

    always_comb
    begin
        acc_t e [16];
        logic [CW:0] st;
        for (int i = 0; i < 16; i++)
            e[i] = ext_p(p2_reg[i]);
        case (op2_reg) inside
            qalu_pkg::OP_MUL:
            begin
                acc3_next[0] = e[0] - e[1] - e[2] - e[3];
                acc3_next[1] = e[4] + e[5] + e[6] - e[7];
                acc3_next[2] = e[8] + e[9] + e[10] - e[11];
                acc3_next[3] = e[12] + e[13] + e[14] - e[15];
            end
            qalu_pkg::OP_DOT, qalu_pkg::OP_NORMSQ:
            begin
                acc3_next[0] = e[0] + e[1] + e[2] + e[3];
                acc3_next[1] = '0;
                acc3_next[2] = '0;
                acc3_next[3] = '0;
            end
            qalu_pkg::OP_SCALE:
            begin
                acc3_next[0] = e[0];
                acc3_next[1] = e[4];
                acc3_next[2] = e[8];
                acc3_next[3] = e[12];
            end
            default:
                acc3_next = s2_reg;
        endcase
        tovf3_next = 1'b0;
        st = sat((e[6] - e[7]) <<< 1);
        t3_next[0] = st[CW-1:0];
        tovf3_next = tovf3_next | st[CW];
        st = sat((e[10] - e[11]) <<< 1);
        t3_next[1] = st[CW-1:0];
        tovf3_next = tovf3_next | st[CW];
        st = sat((e[14] - e[15]) <<< 1);
        t3_next[2] = st[CW-1:0];
        tovf3_next = tovf3_next | st[CW];
    end

    acc_t  acc3_reg [4];
    comp_t t3_reg [3];
    logic  tovf3_reg;
    logic  eq3_reg;
    logic [qalu_pkg::OP_W-1:0] op3_reg;
    comp_t a3_reg [4];
    comp_t b3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            acc3_reg  <= acc3_next;
            t3_reg    <= t3_next;
            tovf3_reg <= tovf3_next && (op2_reg == qalu_pkg::OP_ROTATE);
            eq3_reg   <= eq2_reg;
            op3_reg   <= op2_reg;
            a3_reg    <= a2_reg;
            for (int i = 0; i < 3; i++)
                b3_reg[i] <= b2_reg[i+1];
        end
    end

    // Stage 4: second-round rotate products a_w*t and cross(A.xyz, t).
    comp_t qa [9];
    comp_t qb [9];

    always_comb
    begin
        qa[0] = a3_reg[0]; qb[0] = t3_reg[0];
        qa[1] = a3_reg[2]; qb[1] = t3_reg[2];
        qa[2] = a3_reg[3]; qb[2] = t3_reg[1];
        qa[3] = a3_reg[0]; qb[3] = t3_reg[1];
        qa[4] = a3_reg[3]; qb[4] = t3_reg[0];
        qa[5] = a3_reg[1]; qb[5] = t3_reg[2];
        qa[6] = a3_reg[0]; qb[6] = t3_reg[2];
        qa[7] = a3_reg[1]; qb[7] = t3_reg[1];
        qa[8] = a3_reg[2]; qb[8] = t3_reg[0];
    end

    prod_t q4_reg [9];
    acc_t  acc4_reg [4];
    logic  tovf4_reg;
    logic  eq4_reg;
    logic [qalu_pkg::OP_W-1:0] op4_reg;
    comp_t b4_reg [3];

    for (genvar g = 0; g < 9; g++)
    begin : g_mul2
        logic signed [2*CW-1:0] prod;
        assign prod = qa[g] * qb[g];
        always_ff @(posedge clk)
        begin
            if (en4)
                q4_reg[g] <= prod[2*CW-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            acc4_reg  <= acc3_reg;
            tovf4_reg <= tovf3_reg;
            eq4_reg   <= eq3_reg;
            op4_reg   <= op3_reg;
            b4_reg    <= b3_reg;
        end
    end

    // Stage 5: rotated vector v + a_w*t + cross(A.xyz, t).
    acc_t acc5_next [4];

    always_comb
    begin
        if (op4_reg == qalu_pkg::OP_ROTATE)
        begin
            acc5_next[0] = '0;
            acc5_next[1] = ext_c(b4_reg[0]) + ext_p(q4_reg[0]) + ext_p(q4_reg[1])
                         - ext_p(q4_reg[2]);
            acc5_next[2] = ext_c(b4_reg[1]) + ext_p(q4_reg[3]) + ext_p(q4_reg[4])
                         - ext_p(q4_reg[5]);
            acc5_next[3] = ext_c(b4_reg[2]) + ext_p(q4_reg[6]) + ext_p(q4_reg[7])
                         - ext_p(q4_reg[8]);
        end
        else
            acc5_next = acc4_reg;
    end

    acc_t acc5_reg [4];
    logic tovf5_reg;
    logic eq5_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            acc5_reg  <= acc5_next;
            tovf5_reg <= tovf4_reg;
            eq5_reg   <= eq4_reg;
        end
    end

    // Stage 6: saturation and the output register.
    logic [CW-1:0] r6_next [4];
    logic          ovf6_next;

    always_comb
    begin
        logic [CW:0] s;
        ovf6_next = tovf5_reg;
        for (int i = 0; i < 4; i++)
        begin
            s = sat(acc5_reg[i]);
            r6_next[i] = s[CW-1:0];
            ovf6_next = ovf6_next | s[CW];
        end
    end

    logic [CW-1:0] r6_reg [4];
    logic          ovf6_reg;
    logic          eq6_reg;

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            r6_reg   <= r6_next;
            ovf6_reg <= ovf6_next;
            eq6_reg  <= eq5_reg;
        end
    end

    assign m_tdata = {6'b0, eq6_reg, ovf6_reg, r6_reg[3], r6_reg[2], r6_reg[1], r6_reg[0]};

endmodule

/* design/qalu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion ALU port checker
// Watches the top-level ports and flags behavior the design must never show.
// ----------------------------------------------------------------------------
module qalu_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);

    // A stalled result holds its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A matching compare carries no overflow and zero components.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[qalu_pkg::EQ_BIT] |-> m_tdata[qalu_pkg::OVF_BIT:0] == '0)
        else $error("compare result has nonzero fields");

    // The tolerance register always takes a write.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("tolerance write refused");

    // A rising result must have a request accepted the pipeline depth before it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 6) || $past(m_tvalid))
        else $error("result with no matching request");

endmodule

bind quaternion_alu_top qalu_checker u_qalu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
